// ===== hw/rtl/byte_escape_encoder_unit_macros.svh =====
// assertion helpers for the byte escape encoder
`ifndef BYTE_ESCAPE_ENCODER_UNIT_MACROS_SVH
`define BYTE_ESCAPE_ENCODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BEE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BEE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)

`define BEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/bee_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bee_pkg;

    // width of the output byte counter
    localparam int LenBits = 16;
    localparam int LengthW = 16;
    localparam int LimitW  = 16;
    // compare width: room for the counter plus the largest reserve
    localparam int CmpW    = ((LenBits > LimitW) ? LenBits : LimitW) + 1;

    // longest escape run and the bits to count it
    localparam int MaxRun  = 6;
    localparam int RunW    = 3;

    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_ESCAPE_STYLE = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_OUT_LIMIT    = 1'd1;

    localparam logic [LimitW-1:0] LIMIT_RESET = 16'd4096;

    typedef enum logic [1:0] {
        STYLE_COPY      = 2'd0,
        STYLE_BACKSLASH = 2'd1,
        STYLE_XML       = 2'd2
    } style_t;

    typedef logic [MaxRun-1:0][7:0] esc_buf_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               run_last;
        logic               done_res;
        logic               overflow;
        logic [LengthW-1:0] out_length;
    } out_item_t;

    typedef struct packed {
        style_t            style;
        logic [LimitW-1:0] limit;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bee_in_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// two-entry input queue, stall comes straight from a register
module bee_in_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bee_pkg::in_item_t push_item,
    output logic                   full,
    output logic                   item_valid,
    output bee_pkg::in_item_t      item,
    input  wire logic              pop
);

    bee_pkg::in_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && item_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bee_escape.sv =====
`timescale 1ns / 1ps
`default_nettype none

// escape table: one source byte to its run of up to six output bytes
module bee_escape (
    input  wire bee_pkg::style_t        style,
    input  wire logic [7:0]             src_byte,
    output logic [bee_pkg::RunW-1:0]    esc_len,
    output bee_pkg::esc_buf_t           esc_buf
);

    always_comb
    begin
        esc_buf    = '0;
        esc_buf[0] = src_byte;
        esc_len    = bee_pkg::RunW'(1);
        unique case (style)
            bee_pkg::STYLE_BACKSLASH:
            begin
                esc_buf[0] = 8'h5C;
                esc_len    = bee_pkg::RunW'(2);
                unique case (src_byte)
                    8'h00: esc_buf[1] = 8'h30;   // \0
                    8'h09: esc_buf[1] = 8'h74;   // \t
                    8'h0A: esc_buf[1] = 8'h6E;   // \n
                    8'h0D: esc_buf[1] = 8'h72;   // \r
                    8'h5C: esc_buf[1] = 8'h5C;   // double backslash
                    default:
                    begin
                        esc_buf[0] = src_byte;
                        esc_len    = bee_pkg::RunW'(1);
                    end
                endcase
            end
            bee_pkg::STYLE_XML:
            begin
                esc_buf[0] = 8'h26;
                unique case (src_byte)
                    8'h00, 8'h09, 8'h0A, 8'h0D:
                    begin
                        // numeric reference &#xN;
                        esc_buf[1] = 8'h23;
                        esc_buf[2] = 8'h78;
                        esc_buf[4] = 8'h3B;
                        esc_len    = bee_pkg::RunW'(5);
                        unique case (src_byte)
                            8'h00:   esc_buf[3] = 8'h30;
                            8'h09:   esc_buf[3] = 8'h39;
                            8'h0A:   esc_buf[3] = 8'h41;
                            default: esc_buf[3] = 8'h44;
                        endcase
                    end
                    8'h3C:
                    begin
                        esc_buf[1] = 8'h6C;
                        esc_buf[2] = 8'h74;
                        esc_buf[3] = 8'h3B;
                        esc_len    = bee_pkg::RunW'(4);
                    end
                    8'h3E:
                    begin
                        esc_buf[1] = 8'h67;
                        esc_buf[2] = 8'h74;
                        esc_buf[3] = 8'h3B;
                        esc_len    = bee_pkg::RunW'(4);
                    end
                    8'h27:
                    begin
                        esc_buf[1] = 8'h61;
                        esc_buf[2] = 8'h70;
                        esc_buf[3] = 8'h6F;
                        esc_buf[4] = 8'h73;
                        esc_buf[5] = 8'h3B;
                        esc_len    = bee_pkg::RunW'(6);
                    end
                    8'h22:
                    begin
                        esc_buf[1] = 8'h71;
                        esc_buf[2] = 8'h75;
                        esc_buf[3] = 8'h6F;
                        esc_buf[4] = 8'h74;
                        esc_buf[5] = 8'h3B;
                        esc_len    = bee_pkg::RunW'(6);
                    end
                    8'h26:
                    begin
                        esc_buf[1] = 8'h61;
                        esc_buf[2] = 8'h6D;
                        esc_buf[3] = 8'h70;
                        esc_buf[4] = 8'h3B;
                        esc_len    = bee_pkg::RunW'(5);
                    end
                    default:
                    begin
                        esc_buf[0] = src_byte;
                    end
                endcase
            end
            default:
            begin
                esc_buf[0] = src_byte;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bee_encode_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// room check, length and overflow state, run buffer and output register
module bee_encode_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bee_pkg::cfg_t     cfg,
    input  wire logic              item_valid,
    input  wire bee_pkg::in_item_t item,
    output logic                   pop,
    output logic                   out_valid,
    output bee_pkg::out_item_t     out_data,
    input  wire logic              out_stall
);

    localparam logic [bee_pkg::CmpW-1:0] LenMax =
        bee_pkg::CmpW'({bee_pkg::LenBits{1'b1}});

    // counter state
    logic [bee_pkg::LenBits-1:0] count_reg;
    logic [bee_pkg::LenBits-1:0] count_next;
    logic                        ovf_reg;
    logic                        ovf_next;

    // run buffer
    logic                        ser_active_reg;
    logic                        ser_active_next;
    bee_pkg::esc_buf_t           ser_buf_reg;
    bee_pkg::esc_buf_t           ser_buf_next;
    logic [bee_pkg::RunW-1:0]    ser_n_reg;
    logic [bee_pkg::RunW-1:0]    ser_n_next;
    logic [bee_pkg::RunW-1:0]    ser_k_reg;
    logic [bee_pkg::RunW-1:0]    ser_k_next;
    logic                        ser_bytes_reg;
    logic                        ser_bytes_next;
    logic                        ser_last_reg;
    logic                        ser_last_next;
    logic                        ser_ovf_reg;
    logic                        ser_ovf_next;
    logic [bee_pkg::LengthW-1:0] ser_len_reg;
    logic [bee_pkg::LengthW-1:0] ser_len_next;

    // output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    bee_pkg::out_item_t          out_item_reg;
    bee_pkg::out_item_t          out_item_next;

    bee_pkg::style_t             style_eff;
    logic [bee_pkg::RunW-1:0]    esc_len;
    bee_pkg::esc_buf_t           esc_buf;
    logic [bee_pkg::CmpW-1:0]    limit_clamp;
    logic [bee_pkg::CmpW-1:0]    reserve;
    logic                        room;
    logic [bee_pkg::RunW-1:0]    run_n;
    logic [bee_pkg::RunW-1:0]    items;
    logic [bee_pkg::LenBits-1:0] count_after;
    logic                        ovf_after;
    logic                        out_load;
    logic                        ser_final;
    logic                        ser_free;

    // unused style code behaves as plain copy
    always_comb
    begin
        unique case (cfg.style)
            bee_pkg::STYLE_BACKSLASH: style_eff = bee_pkg::STYLE_BACKSLASH;
            bee_pkg::STYLE_XML:       style_eff = bee_pkg::STYLE_XML;
            default:                  style_eff = bee_pkg::STYLE_COPY;
        endcase
    end

    bee_escape u_escape (
        .style    (style_eff),
        .src_byte (item.in_byte),
        .esc_len  (esc_len),
        .esc_buf  (esc_buf)
    );

    always_comb
    begin
        unique case (style_eff)
            bee_pkg::STYLE_BACKSLASH: reserve = bee_pkg::CmpW'(1);
            bee_pkg::STYLE_XML:       reserve = bee_pkg::CmpW'(7);
            default:                  reserve = '0;
        endcase
    end

    assign limit_clamp = (bee_pkg::CmpW'(cfg.limit) > LenMax) ? LenMax
                                                              : bee_pkg::CmpW'(cfg.limit);
    assign room        = !ovf_reg && ((bee_pkg::CmpW'(count_reg) + reserve) < limit_clamp);
    assign run_n       = room ? esc_len : '0;
    assign count_after = count_reg + bee_pkg::LenBits'(run_n);
    assign ovf_after   = ovf_reg || !room;
    // a dropped final byte still reports the totals in one item
    assign items       = room ? esc_len : (item.last_in ? bee_pkg::RunW'(1) : '0);

    assign out_load  = ser_active_reg && (!out_valid_reg || !out_stall);
    assign ser_final = (ser_k_reg == (ser_n_reg - bee_pkg::RunW'(1)));
    assign ser_free  = !ser_active_reg || (out_load && ser_final);
    assign pop       = item_valid && ser_free;

    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        ser_active_next = ser_active_reg;
        ser_buf_next    = ser_buf_reg;
        ser_n_next      = ser_n_reg;
        ser_k_next      = ser_k_reg;
        ser_bytes_next  = ser_bytes_reg;
        ser_last_next   = ser_last_reg;
        ser_ovf_next    = ser_ovf_reg;
        ser_len_next    = ser_len_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (out_load)
        begin
            out_valid_next            = 1'b1;
            out_item_next.out_byte    = ser_buf_reg[ser_k_reg];
            out_item_next.byte_valid  = ser_bytes_reg;
            out_item_next.run_last    = ser_final;
            out_item_next.done_res    = ser_final && ser_last_reg;
            out_item_next.overflow    = ser_ovf_reg;
            out_item_next.out_length  = ser_len_reg;
            if (ser_final)
            begin
                ser_active_next = 1'b0;
            end
            else
            begin
                ser_k_next = ser_k_reg + bee_pkg::RunW'(1);
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            count_next = item.last_in ? '0 : count_after;
            ovf_next   = item.last_in ? 1'b0 : ovf_after;
            if (items != '0)
            begin
                ser_active_next = 1'b1;
                ser_buf_next    = room ? esc_buf : '0;
                ser_n_next      = items;
                ser_k_next      = '0;
                ser_bytes_next  = room;
                ser_last_next   = item.last_in;
                ser_ovf_next    = ovf_after;
                ser_len_next    = bee_pkg::LengthW'(count_after);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            ser_active_reg <= 1'b0;
            ser_n_reg      <= '0;
            ser_k_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            ser_active_reg <= ser_active_next;
            ser_n_reg      <= ser_n_next;
            ser_k_reg      <= ser_k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_buf_reg   <= ser_buf_next;
        ser_bytes_reg <= ser_bytes_next;
        ser_last_reg  <= ser_last_next;
        ser_ovf_reg   <= ser_ovf_next;
        ser_len_reg   <= ser_len_next;
        out_item_reg  <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/byte_escape_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming string escaper: one source byte in, its escaped run out one byte per word.
// Plain text, where each input word escapes to a single byte, streams at a word per
// cycle while the output is not stalled; an escape of n bytes holds the input while
// the run buffer drains into the output register, which emits one byte each cycle it
// is not stalled. A two-entry input queue drives in_stall from a register. An accepted
// input word passes through the input queue and the run buffer to the output register.
// A dropped byte yields no output word unless it is the last of the string, in which
// case one word with byte_valid low reports length and overflow. Configuration must be
// written only while the block is idle; the block does not enforce it. cfg_ready is always high.
`include "byte_escape_encoder_unit_macros.svh"

module byte_escape_encoder_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bee_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bee_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bee_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [bee_pkg::CfgDataW-1:0]  cfg_data
);

    bee_pkg::style_t             style_reg;
    bee_pkg::style_t             style_next;
    logic [bee_pkg::LimitW-1:0]  limit_reg;
    logic [bee_pkg::LimitW-1:0]  limit_next;
    bee_pkg::cfg_t               cfg;
    logic                        q_valid;
    bee_pkg::in_item_t           q_item;
    logic                        q_pop;
    logic                        in_push;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        style_next = style_reg;
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bee_pkg::CFG_ESCAPE_STYLE: style_next = bee_pkg::style_t'(cfg_data[1:0]);
                bee_pkg::CFG_OUT_LIMIT:    limit_next = bee_pkg::LimitW'(cfg_data);
                default:                   style_next = style_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg <= bee_pkg::STYLE_COPY;
            limit_reg <= bee_pkg::LIMIT_RESET;
        end
        else
        begin
            style_reg <= style_next;
            limit_reg <= limit_next;
        end
    end

    assign cfg.style = style_reg;
    assign cfg.limit = limit_reg;
    assign in_push   = in_valid && !in_stall;

    bee_in_fifo u_in_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_push),
        .push_item  (in_data),
        .full       (in_stall),
        .item_valid (q_valid),
        .item       (q_item),
        .pop        (q_pop)
    );

    bee_encode_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (q_valid),
        .item       (q_item),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .out_stall  (out_stall)
    );

    // end of string only ever falls on the last word of a run
    `BEE_ASSERT_SAME(a_done_on_run_last, clk, rst_n, out_valid && out_data.done_res, out_data.run_last, "done_res without run_last")

    // a word without a real byte is only the report for a dropped final byte
    `BEE_ASSERT_SAME(a_empty_is_done, clk, rst_n, out_valid && !out_data.byte_valid, out_data.done_res && out_data.overflow && out_data.out_byte == 8'd0, "empty word outside a dropped final byte")

    // after the end of a string the next string starts from zero length
    `BEE_ASSERT_NEXT(a_clear_after_done, clk, rst_n, out_valid && !out_stall && out_data.done_res, !out_valid || out_data.done_res || out_data.out_length != 16'd0, "length not restarted after end of string")

endmodule

`default_nettype wire

// ===== verif/byte_escape_encoder_unit_tb.sv =====
`timescale 1ns / 1ps

module byte_escape_encoder_unit_tb;

    import bee_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 220;

    typedef logic [7:0] byte_list_t[$];

    class escape_scoreboard;
        logic [1:0]        style_reg;
        logic [LimitW-1:0] limit_reg;
        logic [LenBits-1:0] byte_count;
        bit                dropping;
        logic [7:0]        run[$];
        out_item_t         expected_q[$];
        int                mismatches;

        function new();
            style_reg  = STYLE_COPY;
            limit_reg  = LIMIT_RESET;
            byte_count = '0;
            dropping   = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
            if (idx == CFG_ESCAPE_STYLE)
                style_reg = value[1:0];
            else
                limit_reg = value[LimitW-1:0];
        endfunction

        function void push_text(string s);
            for (int i = 0; i < s.len(); i++)
                run.push_back(s[i]);
        endfunction

        function void note_input(in_item_t w);
            int        reserve;
            int        n;
            out_item_t item;
            run.delete();
            case (style_reg)
                STYLE_BACKSLASH: reserve = 1;
                STYLE_XML:       reserve = 7;
                default:         reserve = 0;
            endcase
            if (!dropping && (int'(byte_count) + reserve < int'(limit_reg)))
            begin
                case (style_reg)
                    STYLE_BACKSLASH:
                    begin
                        case (w.in_byte)
                            8'h00:   push_text("\\0");
                            8'h09:   push_text("\\t");
                            8'h0A:   push_text("\\n");
                            8'h0D:   push_text("\\r");
                            8'h5C:   push_text("\\\\");
                            default: run.push_back(w.in_byte);
                        endcase
                    end
                    STYLE_XML:
                    begin
                        case (w.in_byte)
                            8'h00:   push_text("&#x0;");
                            8'h09:   push_text("&#x9;");
                            8'h0A:   push_text("&#xA;");
                            8'h0D:   push_text("&#xD;");
                            8'h3C:   push_text("&lt;");
                            8'h3E:   push_text("&gt;");
                            8'h27:   push_text("&apos;");
                            8'h22:   push_text("&quot;");
                            8'h26:   push_text("&amp;");
                            default: run.push_back(w.in_byte);
                        endcase
                    end
                    // unused style code behaves as copy
                    default: run.push_back(w.in_byte);
                endcase
            end
            else
                dropping = 1'b1;
            n = run.size();
            byte_count = byte_count + LenBits'(n);
            for (int k = 0; k < n; k++)
            begin
                item.out_byte   = run[k];
                item.byte_valid = 1'b1;
                item.run_last   = (k == n - 1);
                item.done_res   = (k == n - 1) && w.last_in;
                item.overflow   = dropping;
                item.out_length = byte_count;
                expected_q.push_back(item);
            end
            // a dropped final byte still reports length and overflow
            if (n == 0 && w.last_in)
            begin
                item.out_byte   = 8'h00;
                item.byte_valid = 1'b0;
                item.run_last   = 1'b1;
                item.done_res   = 1'b1;
                item.overflow   = dropping;
                item.out_length = byte_count;
                expected_q.push_back(item);
            end
            if (w.last_in)
            begin
                byte_count = '0;
                dropping   = 1'b0;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: byte %02h valid %0b run_last %0b done %0b ovf %0b len %0d",
                             got.out_byte, got.byte_valid, got.run_last, got.done_res,
                             got.overflow, got.out_length);
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.run_last !== want.run_last || got.done_res !== want.done_res ||
                got.overflow !== want.overflow || got.out_length !== want.out_length)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected byte %02h valid %0b run_last %0b done %0b ovf %0b len %0d, got byte %02h valid %0b run_last %0b done %0b ovf %0b len %0d",
                             $realtime, want.out_byte, want.byte_valid, want.run_last,
                             want.done_res, want.overflow, want.out_length,
                             got.out_byte, got.byte_valid, got.run_last, got.done_res,
                             got.overflow, got.out_length);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_item_t            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    escape_scoreboard sb = new();
    bit               in_steady = 1'b0;
    bit               out_steady = 1'b0;
    bit               hold_request = 1'b0;
    int               words_sent = 0;

    byte_escape_encoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL byte_escape_encoder_unit");
        $finish;
    end

    // receiver: random stall, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !out_steady && ($urandom_range(99) < 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    task automatic send_word(logic [7:0] b, logic last);
        in_item_t w;
        w.in_byte = b;
        w.last_in = last;
        if (!in_steady)
        begin
            while ($urandom_range(99) < 29)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic send_run(byte_list_t bytes, bit close);
        foreach (bytes[i])
            send_word(bytes[i], close && (i == bytes.size() - 1));
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic end_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, let every expected word arrive, then let dropped bytes clear
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte(bit escapes_likely);
        byte_list_t specials;
        specials = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h5C, 8'h3C, 8'h3E, 8'h27, 8'h22, 8'h26};
        if (escapes_likely && $urandom_range(1) == 1)
            return specials[$urandom_range(specials.size() - 1)];
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [LimitW-1:0] pick_limit();
        case ($urandom_range(7))
            0:       return '0;
            1:       return LimitW'($urandom_range(1, 8));
            2:       return {LimitW{1'b1}};
            3:       return LIMIT_RESET;
            4:       return LimitW'($urandom);
            default: return LimitW'($urandom_range(9, 80));
        endcase
    endfunction

    initial
    begin
        byte_list_t seq;
        int         phase;
        int         strings;
        int         len;
        bit         tidy;
        bit         leave_open;
        logic [1:0] style;
        logic [CfgDataW-1:0] style_word;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: copy, extremes of the byte
        seq = '{8'h00, 8'hFF};
        send_run(seq, 1'b1);
        drain();

        write_reg(CFG_ESCAPE_STYLE, CfgDataW'(STYLE_BACKSLASH));
        end_cfg();
        seq = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h5C, 8'h41};
        send_run(seq, 1'b1);
        drain();

        write_reg(CFG_ESCAPE_STYLE, CfgDataW'(STYLE_XML));
        end_cfg();
        seq = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h3C, 8'h3E, 8'h27, 8'h22, 8'h26, 8'h7A};
        send_run(seq, 1'b1);
        drain();

        // unused style code, zero capacity: dropped final byte
        write_reg(CFG_ESCAPE_STYLE, 16'd3);
        write_reg(CFG_OUT_LIMIT, '0);
        end_cfg();
        send_word(8'h61, 1'b1);
        drain();

        // dropped byte mid-string, then dropping persists across a roomier setting
        write_reg(CFG_ESCAPE_STYLE, CfgDataW'(STYLE_BACKSLASH));
        write_reg(CFG_OUT_LIMIT, 16'd3);
        end_cfg();
        seq = '{8'h61, 8'h62, 8'h63};
        send_run(seq, 1'b0);
        drain();
        write_reg(CFG_ESCAPE_STYLE, CfgDataW'(STYLE_COPY));
        write_reg(CFG_OUT_LIMIT, 16'hFFFF);
        end_cfg();
        send_word(8'h64, 1'b1);
        drain();

        write_reg(CFG_ESCAPE_STYLE, CfgDataW'(STYLE_XML));
        write_reg(CFG_OUT_LIMIT, 16'd8);
        end_cfg();
        seq = '{8'h26, 8'h41};
        send_run(seq, 1'b1);

        phase = 0;
        while (words_sent < RANDOM_WORDS || phase <= 7)
        begin
            drain();
            in_steady  = 1'b0;
            out_steady = 1'b0;
            style = 2'($urandom_range(3));
            style_word = {($urandom_range(3) == 0) ? 14'($urandom) : 14'd0, style};
            case ($urandom_range(3))
                0: write_reg(CFG_ESCAPE_STYLE, style_word);
                1: write_reg(CFG_OUT_LIMIT, pick_limit());
                2:
                begin
                    write_reg(CFG_ESCAPE_STYLE, style_word);
                    write_reg(CFG_OUT_LIMIT, pick_limit());
                end
                default: ;
            endcase
            end_cfg();

            if (phase == 4)
            begin
                // no idling on either side
                in_steady  = 1'b1;
                out_steady = 1'b1;
            end
            if (phase == 7)
            begin
                // receiver holds off while the sender keeps offering
                write_reg(CFG_ESCAPE_STYLE, CfgDataW'(STYLE_XML));
                write_reg(CFG_OUT_LIMIT, LIMIT_RESET);
                end_cfg();
                in_steady = 1'b1;
                hold_request = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_word(pick_byte(1'b1), i == 39);
                in_steady = 1'b0;
            end
            else
            begin
                strings = (phase == 4) ? 4 : $urandom_range(1, 4);
                for (int s = 0; s < strings; s++)
                begin
                    len = (phase == 4) ? 10 : $urandom_range(1, 10);
                    tidy = $urandom_range(99) < 75;
                    leave_open = (s == strings - 1) && ($urandom_range(99) < 15);
                    for (int i = 0; i < len; i++)
                    begin
                        if (tidy)
                            send_word(pick_byte(1'b1), (i == len - 1) && !leave_open);
                        else
                            send_word(pick_byte(1'b0), 1'($urandom_range(7) == 0));
                    end
                end
            end
            phase++;
        end

        in_steady  = 1'b0;
        out_steady = 1'b0;
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS byte_escape_encoder_unit");
        else
            $display("FAIL byte_escape_encoder_unit");
        $finish;
    end

endmodule
